// ===== src/tqd_pkg.sv =====
`default_nettype none

package tqd_pkg;

	localparam logic FUNC_SUBMIT = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	localparam logic CORE_VECTOR = 1'b0;
	localparam logic CORE_TENSOR = 1'b1;

	localparam logic [2:0] TT_MATMUL = 3'd0;
	localparam logic [2:0] TT_CONV2D = 3'd1;
	localparam logic [2:0] TT_VADD   = 3'd2;
	localparam logic [2:0] TT_VMUL   = 3'd3;
	localparam logic [2:0] TT_VFMA   = 3'd4;

	localparam logic [1:0] CFG_VECTOR_PRESENT = 2'd0;
	localparam logic [1:0] CFG_TENSOR_PRESENT = 2'd1;

	typedef struct packed {
		logic        func;
		logic [2:0]  task_type;
		logic [31:0] task_word;
		logic        vector_busy;
		logic        tensor_busy;
		logic        vector_idle;
		logic        tensor_idle;
		logic        vector_ready;
		logic        tensor_ready;
	} tqd_in_t;

	typedef struct packed {
		logic        submit_ok;
		logic        dispatched;
		logic        target_core;
		logic [2:0]  out_type;
		logic [31:0] out_word;
		logic [4:0]  queue_level;
		logic [31:0] tasks_submitted;
		logic [31:0] ticks_seen;
		logic [31:0] vector_busy_ticks;
		logic [31:0] tensor_busy_ticks;
		logic [31:0] vector_dispatches;
		logic [31:0] tensor_dispatches;
	} tqd_out_t;

	// classified item handed from front to back
	typedef struct packed {
		logic        is_tick;
		logic [2:0]  task_type;
		logic [31:0] task_word;
		logic        vbusy_cnt;
		logic        tbusy_cnt;
		logic        other_core;
		logic        vec_take;
		logic        ten_take;
	} tqd_cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_HEAD
	} tqd_bk_state_t;

endpackage

`default_nettype wire

// ===== src/tqd_front.sv =====
`default_nettype none

module tqd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	input  wire logic [1:0]       cfg_index,
	input  wire logic             cfg_data,
	input  wire logic             in_valid,
	input  wire tqd_pkg::tqd_in_t in_item,
	output logic                  in_ready,
	input  wire logic             q_ready,
	output logic                  q_push,
	output tqd_pkg::tqd_cmd_t     q_cmd
);
	import tqd_pkg::*;

	logic vector_present_q;
	logic tensor_present_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_present_q <= 1'b0;
			tensor_present_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_VECTOR_PRESENT: vector_present_q <= cfg_data;
				CFG_TENSOR_PRESENT: tensor_present_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		q_cmd.is_tick   = (in_item.func == FUNC_TICK);
		q_cmd.task_type = in_item.task_type;
		q_cmd.task_word = in_item.task_word;
		q_cmd.vbusy_cnt = vector_present_q & in_item.vector_busy;
		q_cmd.tbusy_cnt = tensor_present_q & in_item.tensor_busy;
		// choice for types without a fixed core
		if (vector_present_q && in_item.vector_idle)
			q_cmd.other_core = CORE_VECTOR;
		else if (tensor_present_q && in_item.tensor_idle)
			q_cmd.other_core = CORE_TENSOR;
		else
			q_cmd.other_core = CORE_VECTOR;
		q_cmd.vec_take = vector_present_q & in_item.vector_ready;
		q_cmd.ten_take = tensor_present_q & in_item.tensor_ready;
	end

	assign in_ready = q_ready;
	assign q_push   = in_valid & q_ready;

endmodule

`default_nettype wire

// ===== src/tqd_fifo.sv =====
`default_nettype none

module tqd_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire tqd_pkg::tqd_cmd_t push_cmd,
	output logic                   push_ready,
	input  wire logic              pop,
	output logic                   pop_valid,
	output tqd_pkg::tqd_cmd_t      pop_cmd
);
	import tqd_pkg::*;

	tqd_cmd_t   slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push & push_ready;
	assign do_pop     = pop & pop_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

`default_nettype wire

// ===== src/tqd_back.sv =====
`default_nettype none

module tqd_back #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	input  wire tqd_pkg::tqd_cmd_t cmd_data,
	output logic                   cmd_pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output tqd_pkg::tqd_out_t      out_item
);
	import tqd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ENT_W = PAYLOAD_BITS + 3;

	function automatic logic route(input logic [2:0] kind, input logic other_core);
		logic core;
		unique case (kind) inside
			TT_MATMUL, TT_CONV2D:     core = CORE_TENSOR;
			TT_VADD, TT_VMUL, TT_VFMA: core = CORE_VECTOR;
			default:                  core = other_core;
		endcase
		return core;
	endfunction

	logic [ENT_W-1:0] mem [QUEUE_DEPTH];
	logic [ENT_W-1:0] rd_q;
	tqd_cmd_t         cmd_q;
	tqd_bk_state_t    state_q, state_d;
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] fill_q, fill_d;
	logic [31:0]      sub_q, ticks_q, vbusy_q, tbusy_q, vdisp_q, tdisp_q;
	logic [31:0]      sub_d, ticks_d, vbusy_d, tbusy_d, vdisp_d, tdisp_d;
	logic             out_valid_q;
	tqd_out_t         out_q, res;

	logic             out_free, emit, rd_en, push, pop_task, tick_done;
	logic             full, head_core, head_take;
	tqd_cmd_t         tick_cmd;
	logic [2:0]       head_type;
	logic [63:0]      word_in_ext, head_word_ext;

	assign out_free      = !out_valid_q || out_ready;
	assign full          = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign head_type     = rd_q[ENT_W-1 -: 3];
	assign head_word_ext = 64'(rd_q[PAYLOAD_BITS-1:0]);
	assign word_in_ext   = {32'd0, cmd_data.task_word};
	assign head_core     = route(head_type, cmd_q.other_core);
	assign head_take     = (head_core == CORE_VECTOR) ? cmd_q.vec_take : cmd_q.ten_take;
	assign tick_cmd      = (state_q == BK_HEAD) ? cmd_q : cmd_data;

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		emit      = 1'b0;
		rd_en     = 1'b0;
		push      = 1'b0;
		pop_task  = 1'b0;
		tick_done = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					if (!cmd_data.is_tick) begin
						emit = 1'b1;
						push = !full;
					end else if (fill_q == '0) begin
						emit      = 1'b1;
						tick_done = 1'b1;
					end else begin
						rd_en   = 1'b1;
						state_d = BK_HEAD;
					end
				end
			end
			BK_HEAD: begin
				if (out_free) begin
					emit      = 1'b1;
					tick_done = 1'b1;
					pop_task  = head_take;
					state_d   = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		sub_d   = sub_q + 32'(push);
		ticks_d = ticks_q + 32'(tick_done);
		vbusy_d = vbusy_q + 32'(tick_done & tick_cmd.vbusy_cnt);
		tbusy_d = tbusy_q + 32'(tick_done & tick_cmd.tbusy_cnt);
		vdisp_d = vdisp_q + 32'(pop_task & (head_core == CORE_VECTOR));
		tdisp_d = tdisp_q + 32'(pop_task & (head_core == CORE_TENSOR));
		fill_d  = fill_q + CNT_W'(push) - CNT_W'(pop_task);

		res.submit_ok         = push;
		res.dispatched        = pop_task;
		res.target_core       = pop_task ? head_core : CORE_VECTOR;
		res.out_type          = pop_task ? head_type : 3'd0;
		res.out_word          = pop_task ? head_word_ext[31:0] : 32'd0;
		res.queue_level       = 5'(fill_d);
		res.tasks_submitted   = sub_d;
		res.ticks_seen        = ticks_d;
		res.vector_busy_ticks = vbusy_d;
		res.tensor_busy_ticks = tbusy_d;
		res.vector_dispatches = vdisp_d;
		res.tensor_dispatches = tdisp_d;
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[tail_q] <= {cmd_data.task_type, word_in_ext[PAYLOAD_BITS-1:0]};
		if (rd_en) begin
			rd_q  <= mem[head_q];
			cmd_q <= cmd_data;
		end
		if (emit)
			out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			sub_q       <= '0;
			ticks_q     <= '0;
			vbusy_q     <= '0;
			tbusy_q     <= '0;
			vdisp_q     <= '0;
			tdisp_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			sub_q   <= sub_d;
			ticks_q <= ticks_d;
			vbusy_q <= vbusy_d;
			tbusy_q <= tbusy_d;
			vdisp_q <= vdisp_d;
			tdisp_q <= tdisp_d;
			if (push)
				tail_q <= (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
			if (pop_task)
				head_q <= (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

// ===== src/task_queue_dispatcher.sv =====
// Task queue dispatcher: bounded FIFO of task descriptors routed to a vector or
// tensor core.
// Input channel (in_valid/in_ready/in_item): func 0 submits a task, func 1 is a
// tick carrying the cores' busy/idle/ready status. Every item gives exactly one
// result on the output channel (out_valid/out_ready/out_item) with the submit and
// dispatch outcome, queue level and six wrapping 32-bit counters.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 sets vector
// core present, index 1 tensor core present; other indexes are ignored. Always
// ready; write only while no item is in flight.
// Path: a submit, or a tick on an empty queue, goes through the 2-entry queue
// and the output register; a tick on a non-empty queue also goes through the
// registered read of the head entry from the task memory. Throughput: one
// submit per cycle unless the output stalls; a tick that looks at the head
// adds a BK_HEAD state; a 2-entry queue between front and back absorbs that.
// Reset (arst_n low) empties the task FIFO, clears all counters and both present
// flags. When the receiver stalls, the output register holds its result, the back
// end stops, and in_ready drops once the 2-entry queue is full.
`default_nettype none

module task_queue_dispatcher #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic              cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire tqd_pkg::tqd_in_t  in_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output tqd_pkg::tqd_out_t      out_item
);
	import tqd_pkg::*;

	logic     q_ready, q_push, b_valid, b_pop;
	tqd_cmd_t q_cmd, b_cmd;

	assign cfg_ready = 1'b1;

	tqd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_item   (in_item),
		.in_ready  (in_ready),
		.q_ready   (q_ready),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	tqd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.push_ready (q_ready),
		.pop        (b_pop),
		.pop_valid  (b_valid),
		.pop_cmd    (b_cmd)
	);

	tqd_back #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_data  (b_cmd),
		.cmd_pop   (b_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

// ===== bench/tqd_checker.sv =====
`timescale 1ns / 100ps

module tqd_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic              cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  tqd_pkg::tqd_in_t  in_item,
	input  logic              out_valid,
	input  logic              out_ready,
	input  tqd_pkg::tqd_out_t out_item,
	output int                fail_count,
	output int                pending
);
	import tqd_pkg::*;

	localparam int DEPTH = 16;

	logic [2:0]  slot_type [DEPTH];
	logic [31:0] slot_word [DEPTH];
	logic [3:0]  head_ptr;
	logic [3:0]  tail_ptr;
	logic [4:0]  fill;
	logic [31:0] n_submit;
	logic [31:0] n_tick;
	logic [31:0] n_vbusy;
	logic [31:0] n_tbusy;
	logic [31:0] n_vdisp;
	logic [31:0] n_tdisp;
	logic        vec_on;
	logic        ten_on;
	tqd_out_t    result_q [$];
	tqd_out_t    exp_r;

	function automatic logic pick_core(logic [2:0] kind, logic vidle, logic tidle);
		if (kind == TT_MATMUL || kind == TT_CONV2D)
			return CORE_TENSOR;
		if (kind == TT_VADD || kind == TT_VMUL || kind == TT_VFMA)
			return CORE_VECTOR;
		if (vec_on && vidle)
			return CORE_VECTOR;
		if (ten_on && tidle)
			return CORE_TENSOR;
		return CORE_VECTOR;
	endfunction

	// updates the queue image and counters, returns the result the item must give
	function automatic tqd_out_t advance_queue(tqd_in_t it);
		tqd_out_t r;
		logic     core;
		logic     take;
		r = '0;
		if (it.func == FUNC_SUBMIT) begin
			if (fill < DEPTH) begin
				slot_type[tail_ptr] = it.task_type;
				slot_word[tail_ptr] = it.task_word;
				tail_ptr++;
				fill++;
				n_submit++;
				r.submit_ok = 1'b1;
			end
		end else begin
			n_tick++;
			if (vec_on && it.vector_busy)
				n_vbusy++;
			if (ten_on && it.tensor_busy)
				n_tbusy++;
			if (fill != 0) begin
				core = pick_core(slot_type[head_ptr], it.vector_idle, it.tensor_idle);
				take = (core == CORE_VECTOR) ? (vec_on && it.vector_ready)
				                             : (ten_on && it.tensor_ready);
				if (take) begin
					r.dispatched  = 1'b1;
					r.target_core = core;
					r.out_type    = slot_type[head_ptr];
					r.out_word    = slot_word[head_ptr];
					head_ptr++;
					fill--;
					if (core == CORE_VECTOR)
						n_vdisp++;
					else
						n_tdisp++;
				end
			end
		end
		r.queue_level       = fill;
		r.tasks_submitted   = n_submit;
		r.ticks_seen        = n_tick;
		r.vector_busy_ticks = n_vbusy;
		r.tensor_busy_ticks = n_tbusy;
		r.vector_dispatches = n_vdisp;
		r.tensor_dispatches = n_tdisp;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ptr   = '0;
			tail_ptr   = '0;
			fill       = '0;
			n_submit   = '0;
			n_tick     = '0;
			n_vbusy    = '0;
			n_tbusy    = '0;
			n_vdisp    = '0;
			n_tdisp    = '0;
			vec_on     = 1'b0;
			ten_on     = 1'b0;
			fail_count = 0;
			result_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$error("result with no item outstanding");
					fail_count++;
				end else begin
					exp_r = result_q.pop_front();
					check_field("submit_ok", exp_r.submit_ok, out_item.submit_ok);
					check_field("dispatched", exp_r.dispatched, out_item.dispatched);
					check_field("target_core", exp_r.target_core, out_item.target_core);
					check_field("out_type", exp_r.out_type, out_item.out_type);
					check_field("out_word", exp_r.out_word, out_item.out_word);
					check_field("queue_level", exp_r.queue_level, out_item.queue_level);
					check_field("tasks_submitted", exp_r.tasks_submitted,
						out_item.tasks_submitted);
					check_field("ticks_seen", exp_r.ticks_seen, out_item.ticks_seen);
					check_field("vector_busy_ticks", exp_r.vector_busy_ticks,
						out_item.vector_busy_ticks);
					check_field("tensor_busy_ticks", exp_r.tensor_busy_ticks,
						out_item.tensor_busy_ticks);
					check_field("vector_dispatches", exp_r.vector_dispatches,
						out_item.vector_dispatches);
					check_field("tensor_dispatches", exp_r.tensor_dispatches,
						out_item.tensor_dispatches);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_VECTOR_PRESENT: vec_on = cfg_data;
					CFG_TENSOR_PRESENT: ten_on = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				result_q.push_back(advance_queue(in_item));
		end
		pending = result_q.size();
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	import tqd_pkg::*;

	// indexes the block decodes to nothing
	localparam logic [1:0] CFG_SPARE_A = 2'd2;
	localparam logic [1:0] CFG_SPARE_B = 2'd3;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic       cfg_data  = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	tqd_in_t    in_item   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	tqd_out_t   out_item;
	int         fail_count;
	int         pending;
	int         gap_pct   = 0;
	int         stall_pct = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task_queue_dispatcher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	tqd_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_task(input tqd_in_t it);
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < gap_pct);
		end
		in_item  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic tqd_in_t submit_item(logic [2:0] kind, logic [31:0] word);
		tqd_in_t it;
		it           = '0;
		it.func      = FUNC_SUBMIT;
		it.task_type = kind;
		it.task_word = word;
		return it;
	endfunction

	function automatic tqd_in_t tick_item(logic vb, logic tb, logic vi, logic ti,
			logic vr, logic tr);
		tqd_in_t it;
		it              = '0;
		it.func         = FUNC_TICK;
		it.vector_busy  = vb;
		it.tensor_busy  = tb;
		it.vector_idle  = vi;
		it.tensor_idle  = ti;
		it.vector_ready = vr;
		it.tensor_ready = tr;
		return it;
	endfunction

	function automatic tqd_in_t random_item(int submit_pct);
		tqd_in_t it;
		it.func      = ($urandom_range(99) < submit_pct) ? FUNC_SUBMIT : FUNC_TICK;
		it.task_type = 3'($urandom_range(7));
		case ($urandom_range(7))
			0: it.task_word = '0;
			1: it.task_word = '1;
			default: it.task_word = $urandom;
		endcase
		{it.vector_busy, it.tensor_busy, it.vector_idle, it.tensor_idle} =
			4'($urandom_range(15));
		it.vector_ready = ($urandom_range(3) != 0);
		it.tensor_ready = ($urandom_range(3) != 0);
		return it;
	endfunction

	task automatic run_phase(input int gap, input int stall, input logic vec,
			input logic ten, input int count, input bit hold_mid);
		int submit_pct;
		drain_results();
		write_reg(CFG_VECTOR_PRESENT, vec);
		write_reg(CFG_TENSOR_PRESENT, ten);
		gap_pct    = gap;
		stall_pct  = stall;
		submit_pct = 50;
		for (int i = 0; i < count; i++) begin
			// bursts that fill or drain the queue
			if (i % 20 == 0)
				case ($urandom_range(2))
					0: submit_pct = 15;
					1: submit_pct = 50;
					default: submit_pct = 85;
				endcase
			if (hold_mid && i == count / 2)
				drain_results();
			send_task(random_item(submit_pct));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cores absent: empty tick, fill to the top, refused submit, stuck head
		send_task(tick_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
		for (int k = 0; k < 16; k++)
			send_task(submit_item(3'(k), (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF
				: $urandom));
		send_task(submit_item(TT_VADD, 32'hA5A5_5A5A));
		send_task(tick_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));

		drain_results();
		write_reg(CFG_SPARE_A, 1'b1);
		write_reg(CFG_SPARE_B, 1'b1);
		write_reg(CFG_VECTOR_PRESENT, 1'b1);
		write_reg(CFG_TENSOR_PRESENT, 1'b1);
		send_task(tick_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
		send_task(tick_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
		send_task(tick_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
		send_task(tick_item(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
		send_task(tick_item(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1));
		send_task(tick_item(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1));
		send_task(tick_item(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));

		run_phase(0, 0, 1'b1, 1'b1, 125, 1'b0);
		run_phase(47, 0, 1'b1, 1'b0, 125, 1'b1);
		run_phase(0, 47, 1'b0, 1'b1, 125, 1'b0);
		run_phase(10, 10, 1'b1, 1'b1, 125, 1'b0);

		drain_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
src/tqd_pkg.sv
src/tqd_front.sv
src/tqd_fifo.sv
src/tqd_back.sv
src/task_queue_dispatcher.sv
bench/tqd_checker.sv
bench/testbench.sv
